/* rtl/bbc_pkg.sv */
// Shared types, character codes and error codes for the bracket balance checker.
`default_nettype none

package bbc_pkg;

  // Bracket characters
  localparam logic [7:0] CH_OPEN_ROUND   = 8'h28;  // (
  localparam logic [7:0] CH_CLOSE_ROUND  = 8'h29;  // )
  localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;  // [
  localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;  // ]
  localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B;  // {
  localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D;  // }

  // Error codes carried in the result
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_MISMATCH  = 3'd1;
  localparam logic [2:0] ERR_UNDERFLOW = 3'd2;
  localparam logic [2:0] ERR_OVERFLOW  = 3'd3;
  localparam logic [2:0] ERR_UNCLOSED  = 3'd4;

  // Largest value of the depth field
  localparam int unsigned DEPTH_FIELD_MAX = 127;

  typedef enum logic [1:0] {
    KIND_ROUND  = 2'd0,
    KIND_CURLY  = 2'd1,
    KIND_SQUARE = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } bbc_in_t;

  typedef struct packed {
    logic       balanced;
    logic [2:0] error_code;
    logic [6:0] final_depth;
  } bbc_out_t;

  // Map an opener byte to its kind
  function automatic kind_t opener_kind(input logic [7:0] c);
    kind_t k;
    unique case (c)
      CH_OPEN_ROUND:  k = KIND_ROUND;
      CH_OPEN_CURLY:  k = KIND_CURLY;
      CH_OPEN_SQUARE: k = KIND_SQUARE;
      default:        k = KIND_NONE;
    endcase
    return k;
  endfunction

  // Map a closer byte to its kind
  function automatic kind_t closer_kind(input logic [7:0] c);
    kind_t k;
    unique case (c)
      CH_CLOSE_ROUND:  k = KIND_ROUND;
      CH_CLOSE_CURLY:  k = KIND_CURLY;
      CH_CLOSE_SQUARE: k = KIND_SQUARE;
      default:         k = KIND_NONE;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

/* rtl/bbc_stack_mem.sv */
// Stack storage: one write port, one registered read port with write forwarding.
`default_nettype none

module bbc_stack_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire bbc_pkg::kind_t wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output bbc_pkg::kind_t     rd_data
);
  import bbc_pkg::*;

  kind_t mem [DEPTH];
  kind_t rd_data_r;

  // Write the entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read registered, take the new data when the same entry is written
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* rtl/bbc_out_reg.sv */
// Result output register: holds one verdict transaction until taken.
`default_nettype none

module bbc_out_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire bbc_pkg::bbc_out_t load_data,
  output logic                   busy,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output bbc_pkg::bbc_out_t      out_data
);
  import bbc_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  bbc_out_t data_r;

  // Full and not draining this cycle
  assign busy = valid_r && out_stall;

  // Load a new result, or drop the taken one
  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

/* rtl/bracket_balance_checker.sv */
// Top level of the bracket balance checker: stack control, error tracking, verdict.
//
// Usage:
//   Input channel in_valid / in_stall / in_data carries one character byte per
//   transaction, with last_char marking the end of a string. Output channel
//   out_valid / out_stall / out_data carries one verdict per string: balanced,
//   error_code and final_depth.
//   Throughput is one character per cycle while nothing stalls the input. The
//   top stack entry sits in a register; the entry below it is prefetched from
//   the stack memory every cycle (registered read, forwarded on a push to the
//   same entry), so pushes and pops run back to back.
//   The verdict appears on out_valid in the cycle after the last character is
//   accepted. The stack pointer and the sticky error clear with it, so the
//   next string may start in the following cycle.
//   While a verdict waits under out_stall, ordinary characters are still
//   accepted; a last character is stalled until the waiting verdict is taken.
//   Reset (rst_n low, synchronous) empties the stack, clears the error and
//   drops any pending verdict. The stack memory needs no clearing pass.
`default_nettype none

module bracket_balance_checker #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire bbc_pkg::bbc_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output bbc_pkg::bbc_out_t      out_data
);
  import bbc_pkg::*;

  localparam int unsigned AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned DW  = SPW + 7;

  logic [SPW-1:0] sp_r, sp_nxt, sp_cmt;
  logic [2:0]     err_r, err_nxt, err_cmt;
  kind_t          tos_r, tos_nxt;
  kind_t          below;
  kind_t          ok, ck;

  logic           in_acc;
  logic           out_busy;
  logic           res_load;
  bbc_out_t       res;

  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic [AW-1:0]  rd_addr;
  logic [DW-1:0]  depth_wide;
  logic [2:0]     verdict_err;

  // Stall a last character only while the verdict register is blocked
  assign in_stall = out_busy && in_data.last_char;
  assign in_acc   = in_valid && !in_stall;

  assign ok = opener_kind(in_data.char_code);
  assign ck = closer_kind(in_data.char_code);

  // Apply push or pop, record the first error
  always_comb begin
    sp_nxt  = sp_r;
    err_nxt = err_r;
    tos_nxt = tos_r;
    wr_en   = 1'b0;
    wr_addr = AW'(sp_r - SPW'(1));
    if (in_acc) begin
      priority if (ok != KIND_NONE) begin
        if (sp_r == SPW'(STACK_DEPTH)) begin
          if (err_r == ERR_NONE) err_nxt = ERR_OVERFLOW;
        end else begin
          wr_en   = (sp_r != '0);
          tos_nxt = ok;
          sp_nxt  = sp_r + SPW'(1);
        end
      end else if (ck != KIND_NONE) begin
        if (sp_r == '0) begin
          if (err_r == ERR_NONE) err_nxt = ERR_UNDERFLOW;
        end else begin
          if ((tos_r != ck) && (err_r == ERR_NONE)) err_nxt = ERR_MISMATCH;
          tos_nxt = below;
          sp_nxt  = sp_r - SPW'(1);
        end
      end else begin
        sp_nxt = sp_r;
      end
    end
  end

  // Form the verdict from the state after this character
  assign depth_wide  = DW'(sp_nxt);
  assign verdict_err = ((err_nxt == ERR_NONE) && (sp_nxt != '0)) ? ERR_UNCLOSED : err_nxt;
  assign res_load    = in_acc && in_data.last_char;

  always_comb begin
    res.balanced    = (verdict_err == ERR_NONE);
    res.error_code  = verdict_err;
    res.final_depth = (depth_wide > DW'(DEPTH_FIELD_MAX)) ? 7'(DEPTH_FIELD_MAX)
                                                          : depth_wide[6:0];
  end

  // Clear the state after a verdict
  assign sp_cmt  = res_load ? '0 : sp_nxt;
  assign err_cmt = res_load ? ERR_NONE : err_nxt;

  // Prefetch the entry below the new top
  assign rd_addr = AW'(sp_cmt - SPW'(2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r  <= '0;
      err_r <= ERR_NONE;
    end else begin
      sp_r  <= sp_cmt;
      err_r <= err_cmt;
    end
  end

  always_ff @(posedge clk) begin
    tos_r <= tos_nxt;
  end

  bbc_stack_mem #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_stack_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (tos_r),
    .rd_addr (rd_addr),
    .rd_data (below)
  );

  bbc_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_load),
    .load_data (res),
    .busy      (out_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // The stack never holds more than its depth
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SPW'(STACK_DEPTH))
    else $error("stack pointer beyond depth");

  // A verdict leaves an empty stack and no error behind
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |=> (sp_r == '0) && (err_r == ERR_NONE))
    else $error("state not cleared after verdict");

  // A recorded error sticks until the end of the string
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r != ERR_NONE) && !res_load |=> err_r == $past(err_r))
    else $error("first error overwritten");

  // The pointer moves by at most one per cycle within a string
  a_sp_step: assert property (@(posedge clk) disable iff (!rst_n)
    !res_load |=> (sp_r == $past(sp_r)) || (sp_r == $past(sp_r) + SPW'(1)) ||
                  (sp_r == $past(sp_r) - SPW'(1)))
    else $error("stack pointer jumped");

  // A posted verdict agrees with its error code
  a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.balanced == (out_data.error_code == ERR_NONE))
    else $error("verdict and error code disagree");
`endif

endmodule

`default_nettype wire

/* verif/tb_bracket_balance_checker.sv */
`timescale 1ns / 100ps
// Testbench for bracket_balance_checker: directed and random character streams checked per verdict.
module tb_bracket_balance_checker;
  import bbc_pkg::*;

  localparam int unsigned STACK_DEPTH   = 64;
  localparam int unsigned CHAR_ITEMS    = 1100;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned DRAIN_CYCLES  = 20;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned REPORT_MAX    = 10;

  typedef enum int unsigned {
    FLAW_NONE,
    FLAW_SWAP,
    FLAW_EXTRA_CLOSE,
    FLAW_UNCLOSED
  } flaw_t;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  bbc_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  bbc_out_t out_data;

  bracket_balance_checker #(
    .STACK_DEPTH(STACK_DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // Pending characters, expected verdicts and the string being assembled
  bbc_in_t     char_queue[$];
  bbc_out_t    verdict_queue[$];
  logic [7:0]  draft[$];

  int unsigned total_chars    = 0;
  int unsigned chars_accepted = 0;
  int unsigned fail_count     = 0;
  int unsigned cycle_count    = 0;
  int unsigned hold_left      = 0;
  logic        hold_done      = 1'b0;

  // Predictor state: opener kinds held, depth and the sticky first error
  kind_t       open_stack[STACK_DEPTH];
  int unsigned depth_now    = 0;
  logic [2:0]  sticky_error = ERR_NONE;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] opener_byte(input kind_t k);
    case (k)
      KIND_ROUND: return CH_OPEN_ROUND;
      KIND_CURLY: return CH_OPEN_CURLY;
      default:    return CH_OPEN_SQUARE;
    endcase
  endfunction

  function automatic logic [7:0] closer_byte(input kind_t k);
    case (k)
      KIND_ROUND: return CH_CLOSE_ROUND;
      KIND_CURLY: return CH_CLOSE_CURLY;
      default:    return CH_CLOSE_SQUARE;
    endcase
  endfunction

  function automatic logic is_bracket(input logic [7:0] c);
    case (c)
      CH_OPEN_ROUND, CH_OPEN_CURLY, CH_OPEN_SQUARE,
      CH_CLOSE_ROUND, CH_CLOSE_CURLY, CH_CLOSE_SQUARE: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic kind_t random_kind();
    return kind_t'($urandom_range(2));
  endfunction

  // Any byte that the block ignores
  function automatic logic [7:0] noise_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(255));
    end while (is_bracket(c));
    return c;
  endfunction

  function automatic int unsigned sender_idle_pct();
    case (chars_accepted * 3 / total_chars)
      0:       return 36;
      1:       return 64;
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned receiver_idle_pct();
    case (chars_accepted * 3 / total_chars)
      0:       return 64;
      1:       return 36;
      default: return 0;
    endcase
  endfunction

  // Queue the draft as one string, marking its final character
  task automatic commit_draft();
    bbc_in_t t;
    if (draft.size() == 0) draft.push_back(noise_char());
    foreach (draft[i]) begin
      t.char_code = draft[i];
      t.last_char = (i == draft.size() - 1);
      char_queue.push_back(t);
    end
    draft.delete();
  endtask

  // Nested brackets with noise in between, optionally spoiled
  task automatic add_nested(input int unsigned pairs, input flaw_t flaw);
    kind_t       open_kinds[$];
    kind_t       k;
    int unsigned opened;
    opened = 0;
    while (opened < pairs || open_kinds.size() != 0) begin
      if ($urandom_range(4) == 0) begin
        draft.push_back(noise_char());
      end else if (opened < pairs && (open_kinds.size() == 0 || $urandom_range(1) == 1)) begin
        k = random_kind();
        open_kinds.push_back(k);
        draft.push_back(opener_byte(k));
        opened++;
      end else begin
        k = open_kinds.pop_back();
        if (flaw == FLAW_SWAP && $urandom_range(2) == 0) k = kind_t'((int'(k) + 1) % 3);
        draft.push_back(closer_byte(k));
      end
    end
    case (flaw)
      FLAW_EXTRA_CLOSE: begin
        if ($urandom_range(1) == 1) draft.push_front(closer_byte(random_kind()));
        else draft.push_back(closer_byte(random_kind()));
      end
      FLAW_UNCLOSED: begin
        repeat ($urandom_range(1, 3)) draft.push_back(opener_byte(random_kind()));
      end
      default: ;
    endcase
    if ($urandom_range(9) < 3) draft.push_back(noise_char());
    commit_draft();
  endtask

  // Deep string: a run of openers, then closers for the held ones (round once none are held), ending on noise
  task automatic add_deep(input int unsigned n_open, input int unsigned n_close);
    kind_t held[$];
    kind_t k;
    repeat (n_open) begin
      k = random_kind();
      if (held.size() < STACK_DEPTH) held.push_back(k);
      draft.push_back(opener_byte(k));
    end
    repeat (n_close) begin
      if (held.size() != 0) draft.push_back(closer_byte(held.pop_back()));
      else draft.push_back(CH_CLOSE_ROUND);
    end
    draft.push_back(noise_char());
    commit_draft();
  endtask

  // Unstructured mix of brackets and arbitrary bytes
  task automatic add_scramble(input int unsigned len);
    repeat (len) begin
      if ($urandom_range(1) == 1) begin
        if ($urandom_range(1) == 1) draft.push_back(opener_byte(random_kind()));
        else draft.push_back(closer_byte(random_kind()));
      end else begin
        draft.push_back(8'($urandom_range(255)));
      end
    end
    commit_draft();
  endtask

  function automatic void keep_first_error(input logic [2:0] code);
    if (sticky_error == ERR_NONE) sticky_error = code;
  endfunction

  // Advance the predictor by one accepted character; queue a verdict on the last one
  task automatic track_char(input bbc_in_t t);
    kind_t       open_k;
    kind_t       close_k;
    logic [2:0]  verdict_err;
    int unsigned depth_out;
    bbc_out_t    v;
    open_k  = KIND_NONE;
    close_k = KIND_NONE;
    case (t.char_code)
      CH_OPEN_ROUND:   open_k  = KIND_ROUND;
      CH_OPEN_CURLY:   open_k  = KIND_CURLY;
      CH_OPEN_SQUARE:  open_k  = KIND_SQUARE;
      CH_CLOSE_ROUND:  close_k = KIND_ROUND;
      CH_CLOSE_CURLY:  close_k = KIND_CURLY;
      CH_CLOSE_SQUARE: close_k = KIND_SQUARE;
      default: ;
    endcase
    if (open_k != KIND_NONE) begin
      if (depth_now >= STACK_DEPTH) begin
        keep_first_error(ERR_OVERFLOW);
      end else begin
        open_stack[depth_now] = open_k;
        depth_now++;
      end
    end else if (close_k != KIND_NONE) begin
      if (depth_now == 0) begin
        keep_first_error(ERR_UNDERFLOW);
      end else begin
        if (open_stack[depth_now - 1] != close_k) keep_first_error(ERR_MISMATCH);
        depth_now--;
      end
    end
    if (t.last_char) begin
      verdict_err = sticky_error;
      if (verdict_err == ERR_NONE && depth_now != 0) verdict_err = ERR_UNCLOSED;
      depth_out     = (depth_now > DEPTH_FIELD_MAX) ? DEPTH_FIELD_MAX : depth_now;
      v.balanced    = (verdict_err == ERR_NONE);
      v.error_code  = verdict_err;
      v.final_depth = depth_out[6:0];
      verdict_queue.push_back(v);
      depth_now    = 0;
      sticky_error = ERR_NONE;
    end
  endtask

  task automatic note_failure(input string what, input int unsigned want_val,
                              input int unsigned got_val);
    fail_count++;
    if (fail_count <= REPORT_MAX)
      $display("mismatch at %0t: %s expected %0d got %0d", $time, what, want_val, got_val);
  endtask

  // Drive characters; hold the payload while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        track_char(in_data);
        chars_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (char_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
          in_valid <= 1'b1;
          in_data  <= char_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Stall verdicts at random; once, hold off long enough to back up the input
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && out_valid && chars_accepted > total_chars / 6) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_idle_pct());
    end
  end

  // Compare each taken verdict with the oldest expected one
  always @(posedge clk) begin : check_verdicts
    bbc_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (verdict_queue.size() == 0) begin
        note_failure("verdict with none pending, error_code", 0, out_data.error_code);
      end else begin
        want = verdict_queue.pop_front();
        if (out_data.balanced !== want.balanced)
          note_failure("balanced", want.balanced, out_data.balanced);
        if (out_data.error_code !== want.error_code)
          note_failure("error_code", want.error_code, out_data.error_code);
        if (out_data.final_depth !== want.final_depth)
          note_failure("final_depth", want.final_depth, out_data.final_depth);
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[bracket_balance_checker] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned pick;

    // Directed strings: extremes of the byte, each bracket, each error kind but overflow
    draft = '{8'h00};
    commit_draft();
    draft = '{CH_OPEN_ROUND, CH_OPEN_CURLY, 8'hFF, CH_OPEN_SQUARE,
              CH_CLOSE_SQUARE, CH_CLOSE_CURLY, CH_CLOSE_ROUND};
    commit_draft();
    draft = '{CH_CLOSE_CURLY};
    commit_draft();
    // mismatch pops the top and keeps going
    draft = '{CH_OPEN_ROUND, CH_CLOSE_SQUARE, CH_OPEN_SQUARE};
    commit_draft();
    draft = '{CH_OPEN_CURLY, CH_OPEN_CURLY};
    commit_draft();
    draft = '{CH_CLOSE_ROUND, CH_OPEN_ROUND};
    commit_draft();
    // first error sticks over a later underflow
    draft = '{CH_OPEN_SQUARE, CH_CLOSE_CURLY, CH_CLOSE_ROUND, 8'h80};
    commit_draft();

    // Full stack left open, then overflow followed by underflow
    add_deep(STACK_DEPTH, 0);
    add_deep(STACK_DEPTH + 2, STACK_DEPTH + 3);

    // Random strings, mostly well formed
    while (char_queue.size() < CHAR_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 52) add_nested($urandom_range(1, 8), FLAW_NONE);
      else if (pick < 62) add_nested($urandom_range(1, 8), FLAW_SWAP);
      else if (pick < 70) add_nested($urandom_range(0, 6), FLAW_EXTRA_CLOSE);
      else if (pick < 78) add_nested($urandom_range(0, 6), FLAW_UNCLOSED);
      else if (pick < 90) add_scramble($urandom_range(1, 10));
      else if (pick < 92) add_deep($urandom_range(STACK_DEPTH - 4, STACK_DEPTH + 4),
                                   $urandom_range(0, STACK_DEPTH + 6));
      else add_nested($urandom_range(9, 20), FLAW_NONE);
    end
    total_chars = char_queue.size();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every character to go in and every verdict to come out
    while (char_queue.size() != 0 || in_valid || verdict_queue.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("[bracket_balance_checker] OK");
    end else begin
      $display("[bracket_balance_checker] ERROR");
    end
    $finish;
  end

endmodule
